[rtl/glrc_pkg.sv]
// ----------------------------------------------------------------------------
// glrc_pkg: shared constants for the grid laser ray cast unit
// register indexes, command codes, reset values and fixed-point constants
// ----------------------------------------------------------------------------
`default_nettype none

package glrc_pkg;

    localparam int GRID_W_DEF    = 512;
    localparam int GRID_H_DEF    = 512;
    localparam int MAX_BEAMS_DEF = 1024;

    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BEAM_COUNT = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [9:0]  RST_MAP_WIDTH  = 10'd332;
    localparam logic [9:0]  RST_MAP_HEIGHT = 10'd441;
    localparam logic [10:0] RST_BEAM_COUNT = 11'd144;

    localparam logic signed [7:0] OCC_LIMIT = 8'sd99;

    localparam int STEP_Q32 = 42949673;
    localparam logic [12:0] STEP_LO = 13'(STEP_Q32 % 8192);
    localparam logic [12:0] STEP_HI = 13'(STEP_Q32 / 8192);

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [17:0] MISS_RANGE_Q8 = 18'd51200;
    localparam logic [17:0] SAT_RANGE_Q8  = 18'd262143;

    function automatic logic signed [32:0] atan_q30(input logic [3:0] i);
        logic signed [32:0] v;
        unique case (i)
            4'd0:  v = 33'sd536870912;
            4'd1:  v = 33'sd316933407;
            4'd2:  v = 33'sd167458908;
            4'd3:  v = 33'sd85004756;
            4'd4:  v = 33'sd42667333;
            4'd5:  v = 33'sd21354465;
            4'd6:  v = 33'sd10679839;
            4'd7:  v = 33'sd5340245;
            4'd8:  v = 33'sd2670163;
            4'd9:  v = 33'sd1335087;
            4'd10: v = 33'sd667544;
            4'd11: v = 33'sd333772;
            4'd12: v = 33'sd166886;
            4'd13: v = 33'sd83443;
            4'd14: v = 33'sd41722;
            default: v = 33'sd20861;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/grid_laser_ray_cast_unit.sv]
// ----------------------------------------------------------------------------
// grid_laser_ray_cast_unit: laser beam ray marcher over an occupancy grid
// write transactions fill a one-bit occupancy map, cast transactions march
// ----------------------------------------------------------------------------
// A write transaction in the grid updates one map cell. A cast transaction
// runs bit-serial phase division, 16 CORDIC iterations, step scaling, then a
// march of about 0.0141-cell steps (add, then one map memory read), and on a
// hit offset, squaring and bit-serial square root, then the output register.
// No input is taken until a cast is through. The march loop over the single
// map read port dominates the cast time. The map has no clearing pass: cells
// must be written before a beam can reach them.
`default_nettype none

module grid_laser_ray_cast_unit #(
    parameter int GRID_W    = glrc_pkg::GRID_W_DEF,
    parameter int GRID_H    = glrc_pkg::GRID_H_DEF,
    parameter int MAX_BEAMS = glrc_pkg::MAX_BEAMS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // cell_x[8:0] cell_y[17:9] occupancy[25:18] start_x[50:26]
    // start_y[75:51] beam_index[85:76]
    input  wire logic [87:0] i_s_tdata,
    // cmd[0]
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // beam_number[9:0] range_q8[27:10]
    output logic [31:0]      o_m_tdata,
    // hit[0]
    output logic             o_m_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    localparam int AW = $clog2(GRID_W * GRID_H);
    localparam logic [AW-1:0] GW_A = AW'(GRID_W);
    localparam int PW = 45;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CORD, S_MUL, S_STEP, S_CHK, S_ABS, S_SQ, S_ROOT, S_OUT
    } t_state;

    t_state r_state;
    logic [9:0]  r_width, r_height;
    logic [10:0] r_count;

    logic [5:0]  r_iter;
    logic [9:0]  r_idx, r_dsh;
    logic [10:0] r_div, r_rem;
    logic [31:0] r_q;
    logic [1:0]  r_quad;
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic signed [61:0] r_acc;
    logic signed [27:0] r_dx, r_dy;
    logic signed [PW-1:0] r_px, r_py, r_x0, r_y0;
    logic        r_look, r_rdata, r_hit;
    logic [AW-1:0] rd_addr;
    logic [26:0] r_ex, r_ey;
    logic [55:0] r_v, r_r;
    logic        r_ovalid, r_ohit;
    logic [9:0]  r_onum;
    logic [17:0] r_orange;

    logic mem [GRID_W * GRID_H];

    // input fields
    logic [8:0]  in_cx, in_cy;
    logic signed [7:0] in_occ;
    logic [24:0] in_sx, in_sy;
    logic [9:0]  in_idx;
    assign in_cx  = i_s_tdata[8:0];
    assign in_cy  = i_s_tdata[17:9];
    assign in_occ = i_s_tdata[25:18];
    assign in_sx  = i_s_tdata[50:26];
    assign in_sy  = i_s_tdata[75:51];
    assign in_idx = i_s_tdata[85:76];

    logic s_acc, wr_en;
    logic [AW-1:0] wr_addr;
    logic [10:0] cnt_eff;
    assign s_acc   = i_s_tvalid && o_s_tready;
    assign wr_en   = s_acc && (i_s_tuser == glrc_pkg::CMD_WRITE)
                     && ({4'b0, in_cx} < 13'(GRID_W)) && ({4'b0, in_cy} < 13'(GRID_H));
    assign wr_addr = AW'(in_cy) * GW_A + AW'(in_cx);

    always_comb begin
        if (r_count == 11'd0) begin
            cnt_eff = 11'd1;
        end else if ({2'b0, r_count} > 13'(MAX_BEAMS)) begin
            cnt_eff = 11'(MAX_BEAMS);
        end else begin
            cnt_eff = r_count;
        end
    end

    // divider step
    logic [11:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_dsh[9]};
    assign div_ge = div_t >= {1'b0, r_div};

    // cordic step
    logic signed [33:0] xs, ys;
    logic signed [32:0] atn;
    assign xs  = r_cx >>> r_iter[3:0];
    assign ys  = r_cy >>> r_iter[3:0];
    assign atn = glrc_pkg::atan_q30(r_iter[3:0]);

    // quadrant fold and step scaling multiplier
    logic signed [33:0] fc, fs;
    logic signed [34:0] mul_a;
    logic signed [13:0] mul_k;
    logic signed [48:0] mul_p;
    logic signed [61:0] mul_term;
    always_comb begin
        unique case (r_quad)
            2'd0: begin fc = r_cx;  fs = r_cy;  end
            2'd1: begin fc = -r_cy; fs = r_cx;  end
            2'd2: begin fc = -r_cx; fs = -r_cy; end
            default: begin fc = r_cy; fs = -r_cx; end
        endcase
        mul_a = r_iter[1] ? (35'(fs) + 35'(fc)) : (35'(fc) - 35'(fs));
        mul_k = r_iter[0] ? $signed({1'b0, glrc_pkg::STEP_HI})
                          : $signed({1'b0, glrc_pkg::STEP_LO});
        mul_p = mul_a * mul_k;
        mul_term = r_iter[0] ? (62'(mul_p) <<< 13) : 62'(mul_p);
    end

    // march
    logic signed [PW-1:0] wq, hq, nx, ny;
    logic [9:0] cx10, cy10;
    logic out_map, in_grid;
    assign wq = $signed({3'b0, r_width, 32'b0});
    assign hq = $signed({3'b0, r_height, 32'b0});
    assign nx = r_px + PW'(r_dx);
    assign ny = r_py + PW'(r_dy);
    assign cx10 = r_px[41:32];
    assign cy10 = r_py[41:32];
    assign out_map = (r_px > wq) || (r_px <= 0) || (r_py > hq) || (r_py <= 0);
    assign in_grid = (r_px < wq) && (r_py < hq)
                     && ({3'b0, cx10} < 13'(GRID_W)) && ({3'b0, cy10} < 13'(GRID_H));
    assign rd_addr = AW'(cy10) * GW_A + AW'(cx10);

    // offsets and squares
    logic signed [PW-1:0] ddx, ddy, adx, ady;
    logic [26:0] sq_op;
    logic [53:0] sq_p;
    assign ddx = r_px - r_x0;
    assign ddy = r_py - r_y0;
    assign adx = ddx[PW-1] ? -ddx : ddx;
    assign ady = ddy[PW-1] ? -ddy : ddy;
    assign sq_op = r_iter[0] ? r_ey : r_ex;
    assign sq_p  = sq_op * sq_op;

    // square root step
    logic [55:0] rt_bit, rt_sum;
    logic [19:0] rt_res;
    assign rt_bit = 56'd1 << {r_iter[4:0], 1'b0};
    assign rt_sum = r_r + rt_bit;
    assign rt_res = r_r[27:8];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= (in_occ > glrc_pkg::OCC_LIMIT);
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= glrc_pkg::RST_MAP_WIDTH;
            r_height <= glrc_pkg::RST_MAP_HEIGHT;
            r_count  <= glrc_pkg::RST_BEAM_COUNT;
            r_ovalid <= 1'b0;
            r_look   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    glrc_pkg::CFG_MAP_WIDTH:  r_width  <= i_cfg_data[9:0];
                    glrc_pkg::CFG_MAP_HEIGHT: r_height <= i_cfg_data[9:0];
                    glrc_pkg::CFG_BEAM_COUNT: r_count  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc && (i_s_tuser == glrc_pkg::CMD_CAST)) begin
                        r_idx   <= in_idx;
                        r_dsh   <= in_idx;
                        r_div   <= cnt_eff;
                        r_rem   <= 11'd0;
                        r_iter  <= 6'd0;
                        r_x0    <= $signed({4'b0, in_sx, 16'b0});
                        r_y0    <= $signed({4'b0, in_sy, 16'b0});
                        r_px    <= $signed({4'b0, in_sx, 16'b0});
                        r_py    <= $signed({4'b0, in_sy, 16'b0});
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? 11'(div_t - {1'b0, r_div}) : div_t[10:0];
                    r_q   <= {r_q[30:0], div_ge};
                    r_dsh <= {r_dsh[8:0], 1'b0};
                    if (r_iter == 6'd41) begin
                        r_iter  <= 6'd0;
                        r_state <= S_CORD;
                        r_cx    <= glrc_pkg::CORDIC_X0;
                        r_cy    <= 34'sd0;
                    end else begin
                        r_iter <= r_iter + 6'd1;
                    end
                    if (r_iter == 6'd41) begin
                        r_quad <= r_q[30:29];
                        r_cz   <= $signed({3'b0, r_q[28:0], div_ge});
                    end
                end
                S_CORD: begin
                    if (!r_cz[32]) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - atn;
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + atn;
                    end
                    if (r_iter == 6'd15) begin
                        r_iter  <= 6'd0;
                        r_acc   <= 62'sd0;
                        r_state <= S_MUL;
                    end else begin
                        r_iter <= r_iter + 6'd1;
                    end
                end
                S_MUL: begin
                    if (r_iter[0]) begin
                        r_acc <= 62'sd0;
                        if (r_iter[1]) begin
                            r_dy <= 28'((r_acc + mul_term) >>> 30);
                        end else begin
                            r_dx <= 28'((r_acc + mul_term) >>> 30);
                        end
                    end else begin
                        r_acc <= r_acc + mul_term;
                    end
                    if (r_iter == 6'd3) begin
                        r_look  <= 1'b0;
                        r_state <= S_STEP;
                    end
                    r_iter <= r_iter + 6'd1;
                end
                S_STEP: begin
                    if (r_look && r_rdata) begin
                        r_hit   <= 1'b1;
                        r_state <= S_ABS;
                    end else begin
                        r_px    <= nx;
                        r_py    <= ny;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_look  <= in_grid;
                    if (out_map) begin
                        r_hit   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_ABS: begin
                    r_ex    <= adx[42:16];
                    r_ey    <= ady[42:16];
                    r_iter  <= 6'd0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_iter[0]) begin
                        r_v     <= r_v + 56'(sq_p);
                        r_r     <= 56'd0;
                        r_iter  <= 6'd27;
                        r_state <= S_ROOT;
                    end else begin
                        r_v    <= 56'(sq_p);
                        r_iter <= 6'd1;
                    end
                end
                S_ROOT: begin
                    if (r_v >= rt_sum) begin
                        r_v <= r_v - rt_sum;
                        r_r <= (r_r >> 1) + rt_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    if (r_iter == 6'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_iter <= r_iter - 6'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_onum   <= r_idx;
                        r_ohit   <= r_hit;
                        if (!r_hit) begin
                            r_orange <= glrc_pkg::MISS_RANGE_Q8;
                        end else if (rt_res > 20'(glrc_pkg::SAT_RANGE_Q8)) begin
                            r_orange <= glrc_pkg::SAT_RANGE_Q8;
                        end else begin
                            r_orange <= rt_res[17:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {4'b0, r_orange, r_onum};
    assign o_m_tuser   = r_ohit;

endmodule

`default_nettype wire

[rtl/glrc_checker.sv]
// ----------------------------------------------------------------------------
// glrc_checker: port-level checks for the grid laser ray cast unit
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module glrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a cast transaction blocks the input side
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == glrc_pkg::CMD_CAST) |=> !o_s_tready)
        else $error("input accepted during cast");

    // a miss always reports the fixed range
    a_miss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[27:10] == glrc_pkg::MISS_RANGE_Q8)
        else $error("miss with wrong range");

    // no result straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_laser_ray_cast_unit glrc_checker u_glrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the grid laser ray cast unit
// preloads a walled block of map cells, then sends write and cast transactions
// under several register settings with random idling on both stream sides;
// every cast is traced by an independent fixed-point beam tracer and the
// returned range, hit flag and beam number are compared in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int BLK = 6;
    localparam int IDLE_LIMIT = 1000000;
    localparam longint ATAN [16] = '{
        536870912, 316933407, 167458908, 85004756, 42667333, 21354465,
        10679839, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic               cmd;
        logic [8:0]         cx;
        logic [8:0]         cy;
        logic signed [7:0]  occ;
        logic [24:0]        sx;
        logic [24:0]        sy;
        logic [9:0]         idx;
    } t_grid_op;

    typedef struct {
        logic [9:0]  beam;
        logic [17:0] range_q8;
        logic        hit;
    } t_beam_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [87:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    grid_laser_ray_cast_unit uut (.*);

    t_grid_op  pending_ops[$];
    t_beam_res expected_beams[$];
    t_grid_op  cur_op;
    bit        occ_map [512*512];
    int unsigned map_w = glrc_pkg::RST_MAP_WIDTH, map_h = glrc_pkg::RST_MAP_HEIGHT;
    int unsigned beam_cnt = glrc_pkg::RST_BEAM_COUNT;
    bit          calm = 1'b0;
    int          fails = 0;
    int          idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_beam_res trace_beam(t_grid_op op);
        t_beam_res r;
        longint unsigned cnt, ph, ex, ey, v, root, bit_w;
        longint x, y, z, xs, ys, c, s, dx, dy, x0, y0, px, py, wq, hq, ddx, ddy;
        bit hit;
        cnt = beam_cnt == 0 ? 1 : (beam_cnt > 1024 ? 1024 : beam_cnt);
        ph = ((longint'(op.idx) << 32) / cnt) & 64'hFFFF_FFFF;
        x = glrc_pkg::CORDIC_X0;
        y = 0;
        z = ph & 64'h3FFF_FFFF;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN[i];
            end else begin
                x += ys; y -= xs; z += ATAN[i];
            end
        end
        case (ph[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        dx = ((c - s) * longint'(glrc_pkg::STEP_Q32)) >>> 30;
        dy = ((s + c) * longint'(glrc_pkg::STEP_Q32)) >>> 30;
        x0 = longint'(op.sx) << 16;
        y0 = longint'(op.sy) << 16;
        px = x0;
        py = y0;
        wq = longint'(map_w) << 32;
        hq = longint'(map_h) << 32;
        hit = 1'b0;
        forever begin
            px += dx;
            py += dy;
            if (px > wq || px <= 0 || py > hq || py <= 0) break;
            if (px < wq && py < hq && occ_map[(py >> 32) * 512 + (px >> 32)]) begin
                hit = 1'b1;
                break;
            end
        end
        r.beam = op.idx;
        r.hit = hit;
        if (hit) begin
            ddx = px - x0;
            ddy = py - y0;
            ex = (ddx < 0 ? -ddx : ddx) >> 16;
            ey = (ddy < 0 ? -ddy : ddy) >> 16;
            v = ex * ex + ey * ey;
            root = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w >>= 2;
            while (bit_w != 0) begin
                if (v >= root + bit_w) begin
                    v -= root + bit_w;
                    root = (root >> 1) + bit_w;
                end else begin
                    root >>= 1;
                end
                bit_w >>= 2;
            end
            root >>= 8;
            r.range_q8 = root > glrc_pkg::SAT_RANGE_Q8 ? glrc_pkg::SAT_RANGE_Q8 : root[17:0];
        end else begin
            r.range_q8 = glrc_pkg::MISS_RANGE_Q8;
        end
        return r;
    endfunction

    function automatic t_grid_op cell_write(int cx, int cy, int occ);
        t_grid_op op;
        op = '{default: '0};
        op.cmd = glrc_pkg::CMD_WRITE;
        op.cx = 9'(cx);
        op.cy = 9'(cy);
        op.occ = 8'(occ);
        return op;
    endfunction

    function automatic t_grid_op cast_op(logic [24:0] sx, logic [24:0] sy, logic [9:0] idx);
        t_grid_op op;
        op = '{default: '0};
        op.cmd = glrc_pkg::CMD_CAST;
        op.sx = sx;
        op.sy = sy;
        op.idx = idx;
        op.occ = 8'($urandom);
        return op;
    endfunction

    // start inside the walled block, so every cell read has been written
    function automatic logic [24:0] inner_start();
        return 25'($urandom_range(1 << 16, (BLK - 1) * 65536 - 1));
    endfunction

    function automatic t_grid_op random_cast();
        logic [24:0] sx, sy;
        sx = inner_start();
        sy = inner_start();
        if ($urandom_range(0, 9) < 3) begin
            if (map_h <= 510)
                sy = 25'($urandom_range((map_h + 1) * 65536, 33554431));
            else if (map_w <= 510)
                sx = 25'($urandom_range((map_w + 1) * 65536, 33554431));
        end
        return cast_op(sx, sy, 10'($urandom));
    endfunction

    function automatic t_grid_op random_write();
        int a, b;
        a = $urandom_range(1, BLK - 2);
        b = $urandom_range(1, BLK - 2);
        if ($urandom_range(0, 1)) begin
            a = $urandom_range(0, 511);
            b = $urandom_range(BLK, 511);
            if ($urandom_range(0, 1)) {a, b} = {b, a};
        end
        return cell_write(a, b, $urandom_range(0, 255));
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_s_tvalid || expected_beams.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            glrc_pkg::CFG_MAP_WIDTH:  map_w = val[9:0];
            glrc_pkg::CFG_MAP_HEIGHT: map_h = val[9:0];
            default:                  beam_cnt = val;
        endcase
    endtask

    task automatic run_phase(int w, int h, int cnt, int n);
        wait_drained();
        write_reg(glrc_pkg::CFG_MAP_WIDTH, 11'(w));
        write_reg(glrc_pkg::CFG_MAP_HEIGHT, 11'(h));
        write_reg(glrc_pkg::CFG_BEAM_COUNT, 11'(cnt));
        for (int i = 0; i < n; i++)
            pending_ops.push_back($urandom_range(0, 99) < 35 ? random_write() : random_cast());
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (cur_op.cmd == glrc_pkg::CMD_WRITE)
                occ_map[cur_op.cy * 512 + cur_op.cx] = cur_op.occ > glrc_pkg::OCC_LIMIT;
            else
                expected_beams.push_back(trace_beam(cur_op));
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                cur_op = pending_ops.pop_front();
                i_s_tdata <= {2'b00, cur_op.idx, cur_op.sy, cur_op.sx,
                              cur_op.occ, cur_op.cy, cur_op.cx};
                i_s_tuser <= cur_op.cmd;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_beam_res want;
        if (o_m_tvalid && i_m_tready && i_rst_n) begin
            if (expected_beams.size() == 0) begin
                $display("%0t: unexpected result beam=%0d range=%0d hit=%0b", $time,
                         o_m_tdata[9:0], o_m_tdata[27:10], o_m_tuser);
                fails++;
            end else begin
                want = expected_beams.pop_front();
                if (o_m_tdata[9:0] !== want.beam || o_m_tdata[27:10] !== want.range_q8
                        || o_m_tuser !== want.hit) begin
                    $display("%0t: mismatch expected beam=%0d range=%0d hit=%0b", $time,
                             want.beam, want.range_q8, want.hit);
                    $display("%0t:          actual   beam=%0d range=%0d hit=%0b", $time,
                             o_m_tdata[9:0], o_m_tdata[27:10], o_m_tuser);
                    fails++;
                end
            end
        end
        i_m_tready <= i_rst_n && (calm || $urandom_range(0, 99) >= 7);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready)
                || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // walled block: occupied border, random interior
        for (int yy = 0; yy < BLK; yy++)
            for (int xx = 0; xx < BLK; xx++)
                if (xx == 0 || yy == 0 || xx == BLK - 1 || yy == BLK - 1)
                    pending_ops.push_back(cell_write(xx, yy, $urandom_range(100, 127)));
                else
                    pending_ops.push_back(cell_write(xx, yy, $urandom_range(0, 255)));

        // directed, reset settings
        pending_ops.push_back(cell_write(511, 511, -128));
        pending_ops.push_back(cell_write(2, 2, 127));
        pending_ops.push_back(cell_write(3, 2, 99));
        pending_ops.push_back(cell_write(2, 3, 100));
        pending_ops.push_back(cell_write(3, 3, -1));
        pending_ops.push_back(cast_op(25'd0, 25'd0, 10'd0));
        pending_ops.push_back(cast_op(25'd0, 25'd0, 10'd72));
        pending_ops.push_back(cast_op(25'h1FF_FFFF, 25'h1FF_FFFF, 10'd5));
        pending_ops.push_back(cast_op(25'h02_8000, 25'h02_8000, 10'd0));
        pending_ops.push_back(cast_op(25'h03_8000, 25'h03_8000, 10'd1023));
        pending_ops.push_back(cast_op(25'h01_0000, 25'h04_0000, 10'd144));
        pending_ops.push_back(cast_op(25'h04_1234, 25'h01_8000, 10'd36));
        pending_ops.push_back(cast_op(25'h02_0000, 25'h04_0000, 10'd108));
        for (int i = 0; i < 6; i++)
            pending_ops.push_back($urandom_range(0, 99) < 35 ? random_write() : random_cast());

        run_phase(16, 16, 1, 8);
        run_phase(1, 1, 0, 5);
        calm = 1'b1;
        run_phase(512, 512, 2047, 8);
        wait_drained();
        calm = 1'b0;
        run_phase(512, 512, 1024, 8);
        run_phase(7, 300, 1000, 8);
        run_phase($urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(1, 2047), 8);
        wait_drained();

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
